### hw/rtl/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and constants for the periodic priority task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

	// Default number of task slots
	localparam int unsigned TASK_COUNT_DEF = 8;

	// Fixed field widths of the request and response beats
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned TASK_IDX_W = 6;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned PRIO_W     = 8;

	// Reset value of the priority ceiling
	localparam logic [PRIO_W-1:0] CEILING_RST = 8'hFF;

	// Request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_RUN    = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_EN_NOW = 2'd2,
		MODE_EN_AT  = 2'd3
	} mode_t;

	// Response status codes
	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_BAD_INDEX = 1'b1
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_WR,
		ST_RESP
	} state_t;

	// One word of the task table
	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] due;
		logic              hand;
		logic              en;
	} task_entry_t;

endpackage

### hw/rtl/ppts_in_if.sv
// ----------------------------------------------------------------------------
// ppts_in_if
// Request channel of the task scheduler: valid/ready with one item per beat.
// ----------------------------------------------------------------------------
interface ppts_in_if;
	import ppts_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [TASK_IDX_W-1:0] task_index;
	logic [TIME_W-1:0]     time_value;
	logic [TIME_W-1:0]     period;
	logic [PRIO_W-1:0]     priority_req;
	logic                  has_handler;
	logic                  enable_flag;

	modport source (
		output valid, mode, task_index, time_value, period, priority_req,
		       has_handler, enable_flag,
		input  ready
	);

	modport sink (
		input  valid, mode, task_index, time_value, period, priority_req,
		       has_handler, enable_flag,
		output ready
	);

endinterface

### hw/rtl/ppts_out_if.sv
// ----------------------------------------------------------------------------
// ppts_out_if
// Response channel of the task scheduler: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
interface ppts_out_if;
	import ppts_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  task_found;
	logic [TASK_IDX_W-1:0] chosen_task;
	logic                  status;
	logic [TIME_W-1:0]     run_count;

	modport source (
		output valid, task_found, chosen_task, status, run_count,
		input  ready
	);

	modport sink (
		input  valid, task_found, chosen_task, status, run_count,
		output ready
	);

endinterface

### hw/rtl/periodic_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler
// Fixed-priority periodic task scheduler over a task table held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request beats: run (current time), add task, enable now, enable at
//          time. One request is in flight at a time; ready is high while the
//          controller is idle, even when a response still waits on rsp.
//   rsp  - exactly one response beat per request, held in an output register.
//   cfg  - cfg_we/cfg_wdata write the priority ceiling; write only while idle.
// Steps, from the accept edge to the response register loading:
//   run item        the table RAM is read one entry per cycle in rotated
//                   order, then the chosen task's due time is written back.
//   add / enable    one RAM read, one RAM write-back.
//   bad task index  nothing written.
// Reset clears the per-entry valid bits, so every slot reads as zero, the
// rotation point, the run counter and the output register; the ceiling
// returns to 255. A stalled rsp holds its beat; a finished item waits in the
// response state until the output register frees up.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler #(
	parameter int unsigned TASK_COUNT = ppts_pkg::TASK_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ppts_in_if.sink                     req,
	ppts_out_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [ppts_pkg::PRIO_W-1:0] cfg_wdata
);
	import ppts_pkg::*;

	localparam int unsigned IDX_W = $clog2(TASK_COUNT);
	localparam int unsigned CNT_W = $clog2(TASK_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TASK_COUNT);
	localparam logic [TASK_IDX_W:0] COUNT_EXT = (TASK_IDX_W + 1)'(TASK_COUNT);

	// Controller
	state_t state_q, state_d;

	// Latched request
	mode_t             mode_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] tval_q;
	logic [TIME_W-1:0] per_q;
	logic [PRIO_W-1:0] prio_q;
	logic              hand_q;
	logic              en_q;
	logic              oor_q;

	// Scheduler state
	logic [PRIO_W-1:0] ceiling_q;
	logic [IDX_W-1:0]  rot_q;
	logic [TIME_W-1:0] runs_q;

	// Scan bookkeeping
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  pos_nxt;
	logic              hit_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [TIME_W-1:0] best_due_q;
	logic [TIME_W-1:0] best_per_q;

	// Table RAM and its valid bits
	task_entry_t       mem_q [TASK_COUNT];
	logic [TASK_COUNT-1:0] vld_q;
	task_entry_t       rd_data_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic              rd_vld_s1;
	task_entry_t       cur;

	// Output register
	logic                  out_vld_q;
	logic                  out_found_q;
	logic [TASK_IDX_W-1:0] out_task_q;
	logic                  out_status_q;
	logic [TIME_W-1:0]     out_runs_q;

	// Control
	logic              accept;
	logic              in_range;
	logic              take;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	task_entry_t       mem_wd;
	logic [IDX_W-1:0]  mem_ra;
	logic              resp_load;

	assign accept   = req.valid && req.ready;
	assign in_range = {1'b0, req.task_index} < COUNT_EXT;
	assign pos_nxt  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;

	// Read data of a never-written slot counts as zero
	assign cur = vld_q[addr_s1] ? rd_data_s1 : '0;

	// Candidate test for the entry now on the read port
	assign take = rd_vld_s1 && cur.en && cur.hand && (tval_q > cur.due) &&
	              (cur.prio < best_prio_q);

	// Next state, RAM port control and handshakes
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = cur;
		mem_ra    = pos_q;
		resp_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_ra    = in_range ? req.task_index[IDX_W-1:0] : '0;
				if (req.valid) begin
					if (mode_t'(req.mode) == MODE_RUN) begin
						state_d = ST_SCAN;
					end else if (!in_range) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_WR;
					end
				end
			end
			ST_SCAN: begin
				if (cnt_q == SCAN_END) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				mem_we = hit_q;
				mem_wa = best_idx_q;
				mem_wd = '{period: best_per_q, prio: best_prio_q,
				           due: best_due_q + best_per_q, hand: 1'b1, en: 1'b1};
				state_d = ST_RESP;
			end
			ST_WR: begin
				mem_we = 1'b1;
				unique case (mode_q)
					MODE_ADD: begin
						mem_wd = '{period: per_q, prio: prio_q, due: per_q,
						           hand: hand_q, en: en_q};
					end
					MODE_EN_NOW: begin
						mem_wd.en  = en_q;
						mem_wd.due = (cur.period == '0) ? '0 : tval_q;
					end
					MODE_EN_AT: begin
						mem_wd.en  = en_q;
						mem_wd.due = tval_q;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_vld_q || rsp.ready) begin
					resp_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem_q[mem_ra];
		addr_s1    <= mem_ra;
	end

	// Mark slots written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[mem_wa] <= 1'b1;
		end
	end

	// Latch the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(req.mode);
			idx_q  <= req.task_index[IDX_W-1:0];
			tval_q <= req.time_value;
			per_q  <= req.period;
			prio_q <= req.priority_req;
			hand_q <= req.has_handler;
			en_q   <= req.enable_flag;
			oor_q  <= (mode_t'(req.mode) != MODE_RUN) && !in_range;
		end
	end

	// Priority ceiling register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RST;
		end else if (cfg_we) begin
			ceiling_q <= cfg_wdata;
		end
	end

	// Scan sequencing: issue one read per cycle, evaluate each in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pos_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && (cnt_q != SCAN_END);
			if (accept) begin
				cnt_q <= '0;
				pos_q <= (rot_q == LAST_IDX) ? '0 : rot_q + 1'b1;
				hit_q <= 1'b0;
			end else begin
				if ((state_q == ST_SCAN) && (cnt_q != SCAN_END)) begin
					cnt_q <= cnt_q + 1'b1;
					pos_q <= pos_nxt;
				end
				if (take) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Best candidate so far
	always_ff @(posedge clk) begin
		if (accept) begin
			best_prio_q <= ceiling_q;
			best_idx_q  <= '0;
		end else if (take) begin
			best_prio_q <= cur.prio;
			best_idx_q  <= addr_s1;
			best_due_q  <= cur.due;
			best_per_q  <= cur.period;
		end
	end

	// Rotation point and run counter advance at the end of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q  <= '0;
			runs_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			runs_q <= runs_q + 1'b1;
			if (hit_q) begin
				rot_q <= best_idx_q;
			end
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (resp_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_found_q  <= hit_q;
			out_task_q   <= hit_q ? TASK_IDX_W'(best_idx_q) : '0;
			out_status_q <= oor_q ? STATUS_BAD_INDEX : STATUS_OK;
			out_runs_q   <= runs_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.task_found  = out_found_q;
	assign rsp.chosen_task = out_task_q;
	assign rsp.status      = out_status_q;
	assign rsp.run_count   = out_runs_q;

	// The scan counter never runs past the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SCAN_END)
	else $error("scan counter overran the table");

	// The table is written only in the write-back states
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_WR) || (state_q == ST_UPDATE))
	else $error("table write outside a write-back state");

	// The rotation point always names a real slot
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rot_q} < (IDX_W + 1)'(TASK_COUNT))
	else $error("rotation point out of range");

	// A run finishes its write-back and then answers
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (state_q == ST_RESP))
	else $error("update not followed by response");

	// A bad index never reaches the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> !oor_q)
	else $error("write-back for an out-of-range index");

endmodule

### sim/ppts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_checker
// Scoreboard for the task scheduler. It watches the request, response and
// ceiling write ports and keeps its own copy of the task table. From each
// request beat it predicts one response, then compares the responses field
// by field, in order.
// ----------------------------------------------------------------------------
module ppts_checker
	import ppts_pkg::*;
#(
	parameter int unsigned TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ppts_in_if                req,
	ppts_out_if               rsp,
	input  logic              cfg_we,
	input  logic [PRIO_W-1:0] cfg_wdata,
	output int                fail_count,
	output int                outstanding
);

	typedef struct packed {
		logic                  found;
		logic [TASK_IDX_W-1:0] chosen;
		status_t               status;
		logic [TIME_W-1:0]     runs;
	} sched_result_t;

	// Shadow task table and scheduler state
	logic [TIME_W-1:0] period_tab [TASK_COUNT];
	logic [PRIO_W-1:0] prio_tab   [TASK_COUNT];
	logic [TIME_W-1:0] due_tab    [TASK_COUNT];
	logic              en_tab     [TASK_COUNT];
	logic              hand_tab   [TASK_COUNT];
	int unsigned       last_pick;
	logic [TIME_W-1:0] run_total;
	logic [PRIO_W-1:0] ceiling;

	sched_result_t pending_results [$];
	sched_result_t want;

	task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] exp_val);
		fail_count++;
		if (fail_count <= 40) begin
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, exp_val);
		end
	endtask

	// Apply one request to the shadow table and return the response it earns
	function automatic sched_result_t schedule_step(input mode_t kind,
			input logic [TASK_IDX_W-1:0] idx, input logic [TIME_W-1:0] tval,
			input logic [TIME_W-1:0] per, input logic [PRIO_W-1:0] prio,
			input logic hand, input logic en);
		sched_result_t r;
		int unsigned   pos;
		int unsigned   best;
		int unsigned   bound;
		int unsigned   n;
		logic          hit;
		r        = '0;
		r.status = STATUS_OK;
		if (kind == MODE_RUN) begin
			// scan once around the table, starting one past the last pick
			pos   = (last_pick >= TASK_COUNT) ? 0 : last_pick;
			bound = ceiling;
			best  = 0;
			hit   = 1'b0;
			for (n = 0; n < TASK_COUNT; n++) begin
				pos = (pos + 1 >= TASK_COUNT) ? 0 : pos + 1;
				if (en_tab[pos] && hand_tab[pos] && tval > due_tab[pos] &&
						prio_tab[pos] < bound) begin
					bound = prio_tab[pos];
					best  = pos;
					hit   = 1'b1;
				end
			end
			if (hit) begin
				last_pick     = best;
				due_tab[best] = due_tab[best] + period_tab[best];
			end
			run_total = run_total + 1'b1;
			r.found   = hit;
			r.chosen  = hit ? TASK_IDX_W'(best) : '0;
		end else if (idx >= TASK_COUNT) begin
			r.status = STATUS_BAD_INDEX;
		end else begin
			case (kind)
				MODE_ADD: begin
					period_tab[idx] = per;
					prio_tab[idx]   = prio;
					due_tab[idx]    = per;
					hand_tab[idx]   = hand;
					en_tab[idx]     = en;
				end
				MODE_EN_NOW: begin
					en_tab[idx]  = en;
					due_tab[idx] = (period_tab[idx] == '0) ? '0 : tval;
				end
				default: begin
					en_tab[idx]  = en;
					due_tab[idx] = tval;
				end
			endcase
		end
		r.runs = run_total;
		return r;
	endfunction

	// Track ceiling writes, predict on request beats, check response beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				period_tab[i] = '0;
				prio_tab[i]   = '0;
				due_tab[i]    = '0;
				en_tab[i]     = 1'b0;
				hand_tab[i]   = 1'b0;
			end
			last_pick  = 0;
			run_total  = '0;
			ceiling    = CEILING_RST;
			fail_count = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				ceiling = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				pending_results.push_back(schedule_step(mode_t'(req.mode), req.task_index,
					req.time_value, req.period, req.priority_req, req.has_handler,
					req.enable_flag));
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected response beat", rsp.run_count, '0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.task_found !== want.found) begin
						report_mismatch("task_found", rsp.task_found, want.found);
					end
					if (rsp.chosen_task !== want.chosen) begin
						report_mismatch("chosen_task", rsp.chosen_task, want.chosen);
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", rsp.status, want.status);
					end
					if (rsp.run_count !== want.runs) begin
						report_mismatch("run_count", rsp.run_count, want.runs);
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the periodic priority task scheduler. A short
// directed sequence covers the corner cases of selection, then five random
// phases run under different priority ceilings, all but one with random
// idling on both channels, plus one stall burst and one time-wrap phase.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
	import ppts_pkg::*;

	localparam int unsigned TASKS       = TASK_COUNT_DEF;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 104;
	localparam int unsigned PHASES      = 5;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [PRIO_W-1:0] cfg_wdata;
	int                fail_count;
	int                outstanding;
	bit                calm;
	bit                hold_request;
	logic [TIME_W-1:0] now_ms;

	ppts_in_if  req_if ();
	ppts_out_if rsp_if ();

	periodic_priority_task_scheduler #(
		.TASK_COUNT(TASKS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ppts_checker #(
		.TASK_COUNT(TASKS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response side: random stalls, or one long hold when asked
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			rsp_if.ready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	// End the run when no beat moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("periodic_priority_task_scheduler regression: fail");
		$finish;
	end

	// Offer one request beat, after a random idle gap, and hold it until taken
	task automatic send_item(input mode_t kind, input logic [TASK_IDX_W-1:0] idx,
			input logic [TIME_W-1:0] tval, input logic [TIME_W-1:0] per,
			input logic [PRIO_W-1:0] prio, input logic hand, input logic en);
		while (!calm && $urandom_range(0, 99) < 11) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.mode         <= kind;
		req_if.task_index   <= idx;
		req_if.time_value   <= tval;
		req_if.period       <= per;
		req_if.priority_req <= prio;
		req_if.has_handler  <= hand;
		req_if.enable_flag  <= en;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted response has arrived
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_ceiling(input logic [PRIO_W-1:0] value);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly runs on an advancing clock, mixed with table writes and bad indexes
	task automatic random_item();
		logic [31:0]           junk_a;
		logic [31:0]           junk_b;
		logic [TASK_IDX_W-1:0] idx;
		logic [TIME_W-1:0]     per;
		logic [TIME_W-1:0]     tval;
		logic [PRIO_W-1:0]     prio;
		int unsigned           pick;
		junk_a = $urandom();
		junk_b = $urandom();
		pick   = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 8) begin
			idx = TASK_IDX_W'($urandom_range(TASKS, 63));
		end else begin
			idx = TASK_IDX_W'($urandom_range(0, TASKS - 1));
		end
		case ($urandom_range(0, 9))
			0:       per = '0;
			1:       per = $urandom();
			2:       per = $urandom_range(13, 200);
			default: per = $urandom_range(1, 12);
		endcase
		if ($urandom_range(0, 4) == 0) begin
			prio = PRIO_W'($urandom());
		end else begin
			prio = PRIO_W'($urandom_range(0, 7));
		end
		if (pick < 55) begin
			// advance time, now and then jump anywhere
			now_ms = now_ms + $urandom_range(0, 6);
			tval   = ($urandom_range(0, 99) < 4) ? junk_b : now_ms;
			send_item(MODE_RUN, junk_a[5:0], tval, $urandom(), junk_a[15:8], junk_a[16],
				junk_a[17]);
		end else if (pick < 72) begin
			send_item(MODE_ADD, idx, junk_b, per, prio, $urandom_range(0, 9) != 0,
				$urandom_range(0, 6) != 0);
		end else if (pick < 87) begin
			send_item(MODE_EN_NOW, idx, now_ms, junk_b, junk_a[7:0], junk_a[8],
				$urandom_range(0, 5) != 0);
		end else begin
			tval = ($urandom_range(0, 2) == 0) ? junk_b : now_ms + $urandom_range(0, 20);
			send_item(MODE_EN_AT, idx, tval, per, prio, junk_a[8], $urandom_range(0, 5) != 0);
		end
	endtask

	initial begin
		logic [PRIO_W-1:0] ceiling_plan [PHASES];
		int unsigned       phase;
		int unsigned       n;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		req_if.valid        <= 1'b0;
		req_if.mode         <= MODE_RUN;
		req_if.task_index   <= '0;
		req_if.time_value   <= '0;
		req_if.period       <= '0;
		req_if.priority_req <= '0;
		req_if.has_handler  <= 1'b0;
		req_if.enable_flag  <= 1'b0;
		calm         = 1'b0;
		hold_request = 1'b0;
		now_ms       = '0;
		ceiling_plan = '{8'd0, 8'hFF, PRIO_W'($urandom_range(2, 254)), 8'd1, 8'd8};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, bad indexes, strict due compare, ties, wraps
		send_item(MODE_RUN,    6'd0,  32'd0,          32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_ADD,    6'd0,  32'd0,          32'd5,          8'd3,   1'b1, 1'b1);
		send_item(MODE_ADD,    6'd7,  32'd0,          32'hFFFF_FFFF,  8'd0,   1'b1, 1'b1);
		send_item(MODE_ADD,    6'd8,  32'd1,          32'd1,          8'd1,   1'b1, 1'b1);
		send_item(MODE_EN_NOW, 6'd63, 32'd1,          32'd0,          8'd0,   1'b0, 1'b1);
		send_item(MODE_EN_AT,  6'd40, 32'd1,          32'd0,          8'd0,   1'b0, 1'b1);
		send_item(MODE_RUN,    6'd0,  32'd5,          32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_RUN,    6'd0,  32'd6,          32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_EN_AT,  6'd7,  32'd0,          32'd0,          8'd0,   1'b0, 1'b1);
		send_item(MODE_RUN,    6'd0,  32'd7,          32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_ADD,    6'd1,  32'd0,          32'd0,          8'hFF,  1'b1, 1'b1);
		send_item(MODE_EN_NOW, 6'd1,  32'd100,        32'd0,          8'd0,   1'b0, 1'b1);
		send_item(MODE_ADD,    6'd2,  32'd0,          32'd3,          8'd3,   1'b0, 1'b1);
		send_item(MODE_ADD,    6'd3,  32'd0,          32'd4,          8'd3,   1'b1, 1'b0);
		send_item(MODE_ADD,    6'd4,  32'd0,          32'd2,          8'd3,   1'b1, 1'b1);
		send_item(MODE_RUN,    6'd0,  32'd20,         32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_RUN,    6'd0,  32'd20,         32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_EN_NOW, 6'd0,  32'hFFFF_FFFF,  32'd0,          8'd0,   1'b0, 1'b1);
		send_item(MODE_EN_NOW, 6'd4,  32'd3,          32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_ADD,    6'd6,  32'd0,          32'h8000_0000,  8'd254, 1'b1, 1'b1);
		send_item(MODE_RUN,    6'd0,  32'hFFFF_FFFF,  32'd0,          8'd0,   1'b0, 1'b0);
		send_item(MODE_RUN,    6'd63, 32'd0,          32'hFFFF_FFFF,  8'hFF,  1'b1, 1'b1);

		// Random phases, one ceiling each
		for (phase = 0; phase < PHASES; phase++) begin
			write_ceiling(ceiling_plan[phase]);
			calm   = (phase == 1);
			now_ms = (phase == 3) ? 32'hFFFF_FF80 : $urandom_range(0, 50);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == PHASE_ITEMS / 2) begin
					// stall the response side and keep pushing requests
					hold_request = 1'b1;
					calm         = 1'b1;
					repeat (12) random_item();
					calm = 1'b0;
				end
				random_item();
			end
		end

		wait_for_results();
		repeat (TASKS + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("periodic_priority_task_scheduler regression: pass");
		end else begin
			$display("periodic_priority_task_scheduler regression: fail");
		end
		$finish;
	end

endmodule
